// ===== rtl/gamu_pkg.sv =====
// ----------------------------------------------------------------------------
// gamu_pkg
// Command codes, decoded operation type and the request record passed from
// the front end to the execution back end.
// ----------------------------------------------------------------------------
package gamu_pkg;

  localparam int CMD_W  = 4;
  localparam int ADDR_W = 10;
  localparam int DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_INC  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_DEC  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_FADD = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CAS  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_XCHG = 4'd4;
  localparam logic [CMD_W-1:0] CMD_LOAD = 4'd5;
  localparam logic [CMD_W-1:0] CMD_STOR = 4'd6;
  localparam logic [CMD_W-1:0] CMD_MAX  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_MIN  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_OR   = 4'd9;
  localparam logic [CMD_W-1:0] CMD_AND  = 4'd10;
  localparam logic [CMD_W-1:0] CMD_XOR  = 4'd11;

  typedef enum logic [3:0] {
    OP_INC,
    OP_DEC,
    OP_FADD,
    OP_CAS,
    OP_XCHG,
    OP_LOAD,
    OP_STOR,
    OP_MAX,
    OP_MIN,
    OP_OR,
    OP_AND,
    OP_XOR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] swap;
  } req_t;

endpackage

// ===== rtl/gamu_if.sv =====
// ----------------------------------------------------------------------------
// gamu_req_if / gamu_rsp_if
// Valid/ready channels for atomic requests and their results.
// ----------------------------------------------------------------------------
interface gamu_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [9:0]  word_address;
  logic [31:0] operand_value;
  logic [31:0] swap_value;

  modport source (output valid, cmd, word_address, operand_value, swap_value, input ready);
  modport sink (input valid, cmd, word_address, operand_value, swap_value, output ready);
endinterface

interface gamu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;

  modport source (output valid, result_value, input ready);
  modport sink (input valid, result_value, output ready);
endinterface

// ===== rtl/gamu_ram.sv =====
// ----------------------------------------------------------------------------
// gamu_ram
// Single write port, single read port RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module gamu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gamu_front.sv =====
// ----------------------------------------------------------------------------
// gamu_front
// Accepts request transactions, decodes the command and folds the word
// address onto the store size before handing the request to the queue.
// ----------------------------------------------------------------------------
module gamu_front import gamu_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           hold,
  gamu_req_if.sink                       req,
  output logic                           push,
  output logic [$clog2(STORE_WORDS)-1:0] push_idx,
  output req_t                           push_req,
  input  logic                           full
);

  localparam int AW = $clog2(STORE_WORDS);

  logic              s1_valid;
  logic [ADDR_W-1:0] s1_addr;
  req_t              s1_req;
  op_t               op_dec;
  logic              take;

  always_comb begin
    unique case (req.cmd)
      CMD_INC:  op_dec = OP_INC;
      CMD_DEC:  op_dec = OP_DEC;
      CMD_FADD: op_dec = OP_FADD;
      CMD_CAS:  op_dec = OP_CAS;
      CMD_XCHG: op_dec = OP_XCHG;
      CMD_LOAD: op_dec = OP_LOAD;
      CMD_STOR: op_dec = OP_STOR;
      CMD_MAX:  op_dec = OP_MAX;
      CMD_MIN:  op_dec = OP_MIN;
      CMD_OR:   op_dec = OP_OR;
      CMD_AND:  op_dec = OP_AND;
      CMD_XOR:  op_dec = OP_XOR;
      default:  op_dec = OP_NONE;
    endcase
  end

  assign push      = s1_valid && !full;
  assign req.ready = !hold && (!s1_valid || !full);
  assign take      = req.valid && req.ready;
  assign push_req  = s1_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr         <= req.word_address;
      s1_req.op       <= op_dec;
      s1_req.operand  <= req.operand_value;
      s1_req.swap     <= req.swap_value;
    end
  end

  generate
    if (STORE_WORDS >= (1 << ADDR_W)) begin : g_direct
      assign push_idx = AW'(s1_addr);
    end else begin : g_fold
      // x mod N via exact reciprocal: q = (x * ceil(2^k / N)) >> k, k = 10 + ceil(log2 N)
      localparam int RK = ADDR_W + AW;
      localparam int RM = ((1 << RK) + STORE_WORDS - 1) / STORE_WORDS;
      localparam int MW = $clog2(RM + 1);
      localparam int PW = ADDR_W + MW;

      logic [PW-1:0]       prod;
      logic [ADDR_W-1:0]   q_in;
      logic [ADDR_W-1:0]   s1_q;
      logic [2*ADDR_W-1:0] qn;
      logic [2*ADDR_W-1:0] rem;

      assign prod = PW'(req.word_address) * PW'(RM);
      assign q_in = ADDR_W'(prod >> RK);

      always_ff @(posedge clk) begin
        if (take) begin
          s1_q <= q_in;
        end
      end

      assign qn       = (2*ADDR_W)'(s1_q) * (2*ADDR_W)'(STORE_WORDS);
      assign rem      = (2*ADDR_W)'(s1_addr) - qn;
      assign push_idx = rem[AW-1:0];
    end
  endgenerate

endmodule

// ===== rtl/gamu_queue.sv =====
// ----------------------------------------------------------------------------
// gamu_queue
// Two-entry FIFO decoupling the front end from the execution back end.
// ----------------------------------------------------------------------------
module gamu_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/gamu_back.sv =====
// ----------------------------------------------------------------------------
// gamu_back
// Owns the word store: clears it after reset, then reads, modifies and
// writes one word per transaction (no write for loads or unknown ops),
// forwarding the last write to a following request for the same word.
// ----------------------------------------------------------------------------
module gamu_back import gamu_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           clearing,
  input  logic                           empty,
  input  logic [$clog2(STORE_WORDS)-1:0] head_idx,
  input  req_t                           head_req,
  output logic                           pop,
  gamu_rsp_if.source                     rsp
);

  localparam int AW = $clog2(STORE_WORDS);

  logic [AW-1:0]     clr_idx;
  logic              e_valid;
  logic [AW-1:0]     e_idx;
  req_t              e_req;
  logic              e_fire;
  logic              fwd_hit;
  logic [DATA_W-1:0] fwd_data;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] old;
  logic [DATA_W-1:0] addend;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] nxt;
  logic [DATA_W-1:0] res;
  logic              wr;
  logic              o_valid;
  logic [DATA_W-1:0] o_data;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == AW'(STORE_WORDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign e_fire = e_valid && (!o_valid || rsp.ready);
  assign pop    = !clearing && !empty && (!e_valid || e_fire);

  assign we    = clearing || (e_fire && wr);
  assign waddr = clearing ? clr_idx : e_idx;
  assign wdata = clearing ? '0 : nxt;

  gamu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (pop),
    .raddr (head_idx),
    .rdata (rd_data)
  );

  assign old = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    case (e_req.op)
      OP_INC:  addend = 32'd1;
      OP_DEC:  addend = '1;
      default: addend = e_req.operand;
    endcase
  end

  assign sum = old + addend;

  always_comb begin
    nxt = old;
    res = old;
    wr  = 1'b1;
    case (e_req.op)
      OP_INC, OP_DEC: begin
        nxt = sum;
        res = sum;
      end
      OP_FADD: nxt = sum;
      OP_CAS:  nxt = (old == e_req.operand) ? e_req.swap : old;
      OP_XCHG: nxt = e_req.operand;
      OP_LOAD: wr = 1'b0;
      OP_STOR: begin
        nxt = e_req.operand;
        res = e_req.operand;
      end
      OP_MAX: begin
        nxt = (e_req.operand > old) ? e_req.operand : old;
        res = nxt;
      end
      OP_MIN: begin
        nxt = (e_req.operand < old) ? e_req.operand : old;
        res = nxt;
      end
      OP_OR: begin
        nxt = old | e_req.operand;
        res = nxt;
      end
      OP_AND: begin
        nxt = old & e_req.operand;
        res = nxt;
      end
      OP_XOR: begin
        nxt = old ^ e_req.operand;
        res = nxt;
      end
      default: begin
        res = '0;
        wr  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (pop) begin
        e_valid <= 1'b1;
      end else if (e_fire) begin
        e_valid <= 1'b0;
      end
      if (e_fire) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // read issued in the same cycle as a write to that word sees stale data
  always_ff @(posedge clk) begin
    if (pop) begin
      e_idx    <= head_idx;
      e_req    <= head_req;
      fwd_hit  <= e_fire && wr && (e_idx == head_idx);
      fwd_data <= nxt;
    end
    if (e_fire) begin
      o_data <= res;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.result_value = o_data;

endmodule

// ===== rtl/global_atomic_memory_unit.sv =====
// ----------------------------------------------------------------------------
// global_atomic_memory_unit
// Word store with an atomic read-modify-write engine.
// ----------------------------------------------------------------------------
// Sustains one request transaction per clock cycle while the result side
// does not stall, including back-to-back requests to the same word, which
// are served by forwarding the write of the previous request around the
// store's registered read. An accepted request is captured in the front
// register and then passes through the queue, the store read and the
// execute stage, which registers the result. After reset the store is
// cleared one word per cycle: no request is accepted until every word has
// been cleared. Word addresses are taken modulo STORE_WORDS.
// ----------------------------------------------------------------------------
module global_atomic_memory_unit import gamu_pkg::*; #(
  parameter int STORE_WORDS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  gamu_req_if.sink   req,
  gamu_rsp_if.source rsp
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int QW = AW + $bits(req_t);

  logic          clearing;
  logic          push;
  logic [AW-1:0] push_idx;
  req_t          push_req;
  logic          full;
  logic          pop;
  logic          empty;
  logic [QW-1:0] head;
  logic [AW-1:0] head_idx;
  req_t          head_req;

  gamu_front #(
    .STORE_WORDS (STORE_WORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (clearing),
    .req      (req),
    .push     (push),
    .push_idx (push_idx),
    .push_req (push_req),
    .full     (full)
  );

  gamu_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_idx, push_req}),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  assign head_idx = head[QW-1 -: AW];
  assign head_req = head[$bits(req_t)-1:0];

  gamu_back #(
    .STORE_WORDS (STORE_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .empty    (empty),
    .head_idx (head_idx),
    .head_req (head_req),
    .pop      (pop),
    .rsp      (rsp)
  );

endmodule
